@@ hw/rtl/lcw_pkg.sv @@
`default_nettype none

package lcw_pkg;

  localparam int DEF_MAX_UNITS = 4;

  localparam logic [1:0] ACT_PUT    = 2'd0;
  localparam logic [1:0] ACT_CURSOR = 2'd1;
  localparam logic [1:0] ACT_BRIGHT = 2'd2;
  localparam logic [1:0] ACT_MARQ   = 2'd3;

  localparam logic [1:0] CFG_DISPLAY_MODE = 2'd0;
  localparam logic [1:0] CFG_DEVICE_COUNT = 2'd1;
  localparam logic [1:0] CFG_WRAP_ENABLE  = 2'd2;

  localparam logic [15:0] BRIGHT_WORD = 16'h0a00;
  localparam logic [7:0]  SEG_BAD     = 8'h49;
  localparam logic [7:0]  SEG_ZERO    = 8'h7e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic item_words;
    logic item_put;
    logic last_word;
  } sts_t;

  function automatic logic [7:0] seg_code(input logic [6:0] c);
    logic [7:0] s;
    begin
      case (c)
        7'h20: s = 8'h00;
        7'h2d: s = 8'h01;
        7'h5f: s = 8'h08;
        7'h30: s = SEG_ZERO;
        7'h31: s = 8'h30;
        7'h32: s = 8'h6d;
        7'h33: s = 8'h79;
        7'h34: s = 8'h33;
        7'h35: s = 8'h5b;
        7'h36: s = 8'h5f;
        7'h37: s = 8'h70;
        7'h38: s = 8'h7f;
        7'h39: s = 8'h7b;
        7'h41: s = 8'h77;
        7'h42: s = 8'h1f;
        7'h43: s = 8'h4e;
        7'h44: s = 8'h3d;
        7'h45: s = 8'h4f;
        7'h46: s = 8'h47;
        7'h48: s = 8'h37;
        7'h49: s = 8'h30;
        7'h4a: s = 8'h38;
        7'h4c: s = 8'h0e;
        7'h4e: s = 8'h15;
        7'h4f: s = 8'h1d;
        7'h50: s = 8'h67;
        7'h52: s = 8'h05;
        7'h53: s = 8'h5b;
        7'h54: s = 8'h0f;
        7'h55: s = 8'h3e;
        default: s = SEG_BAD;
      endcase
      return s;
    end
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lcw_ctrl.sv @@
`default_nettype none

module lcw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire lcw_pkg::sts_t st,
  output lcw_pkg::cmd_t      cmd
);

  lcw_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state_r)
      lcw_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.item_words) begin
            state_nxt = lcw_pkg::ST_EMIT;
          end else if (st.item_put) begin
            state_nxt = lcw_pkg::ST_FIN;
          end
        end
      end
      lcw_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.step = 1'b1;
          if (st.last_word) begin
            state_nxt = lcw_pkg::ST_FIN;
          end
        end
      end
      lcw_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = lcw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lcw_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcw_pkg::ST_EMIT) |-> in_stall)
    else $error("input taken while words are pending");
  a_fin_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcw_pkg::ST_FIN) |=> (state_r == lcw_pkg::ST_IDLE))
    else $error("cursor update did not return to idle");
  a_last_word_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && st.last_word) |=> (state_r == lcw_pkg::ST_FIN))
    else $error("emission continued past the final word");
  a_no_double_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.step, cmd.finish}))
    else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/lcw_dp.sv @@
`default_nettype none

module lcw_dp #(
  parameter int MAX_UNITS = lcw_pkg::DEF_MAX_UNITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lcw_pkg::cmd_t cmd,
  output lcw_pkg::sts_t      st,
  input  wire logic [1:0]    in_action,
  input  wire logic [7:0]    in_char_code,
  input  wire logic [1:0]    in_cursor_row,
  input  wire logic [2:0]    in_cursor_col,
  input  wire logic [3:0]    in_level,
  input  wire logic          cfg_valid,
  input  wire logic          cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [2:0]    cfg_data,
  output logic [15:0]        out_frame_word,
  output logic               out_load_after,
  output logic               out_run_last
);

  logic            mode_r, mode_nxt;
  logic [2:0]      count_r, count_nxt;
  logic            wrap_r, wrap_nxt;
  logic [2:0]      unit_r, unit_nxt;
  logic [2:0]      col_r, col_nxt;
  logic [7:0][7:0] cache_r, cache_nxt;
  logic            pend_r, pend_nxt;
  logic [1:0]      act_r, act_nxt;
  logic            gfx_r, gfx_nxt;
  logic [3:0]      level_r, level_nxt;
  logic [15:0]     word_r, word_nxt;
  logic [2:0]      grp_r, grp_nxt;
  logic [2:0]      cnt_r, cnt_nxt;

  logic [2:0]  units;
  logic [3:0]  unit_inc;
  logic        wrap_now;
  logic [7:0]  segs;
  logic [3:0]  pos;
  logic        gfx_put;
  logic [15:0] base_word;
  logic        unit_match;

  always_comb begin
    if (count_r == 3'd0) begin
      units = 3'd1;
    end else if (count_r > 3'(MAX_UNITS)) begin
      units = 3'(MAX_UNITS);
    end else begin
      units = count_r;
    end
  end

  assign segs     = lcw_pkg::seg_code(in_char_code[6:0]) | {in_char_code[7], 7'd0};
  assign pos      = 4'd8 - {1'b0, col_r};
  assign unit_inc = {1'b0, unit_r} + 4'd1;
  assign wrap_now = gfx_r ? (wrap_r | pend_r) : wrap_r;
  assign gfx_put  = (act_r == lcw_pkg::ACT_PUT) && gfx_r;

  assign st.item_put   = (in_action == lcw_pkg::ACT_PUT);
  assign st.item_words = (in_action == lcw_pkg::ACT_BRIGHT) ||
                         ((in_action == lcw_pkg::ACT_PUT) &&
                          (!mode_r || (col_r != 3'd7) || !pend_r));
  assign st.last_word  = (cnt_r == 3'd1) && (!gfx_put || (grp_r == 3'd7));

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    wrap_nxt  = wrap_r;
    unit_nxt  = unit_r;
    col_nxt   = col_r;
    cache_nxt = cache_r;
    pend_nxt  = pend_r;
    act_nxt   = act_r;
    gfx_nxt   = gfx_r;
    level_nxt = level_r;
    word_nxt  = word_r;
    grp_nxt   = grp_r;
    cnt_nxt   = cnt_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lcw_pkg::CFG_DISPLAY_MODE: mode_nxt  = cfg_data[0];
        lcw_pkg::CFG_DEVICE_COUNT: count_nxt = cfg_data;
        lcw_pkg::CFG_WRAP_ENABLE:  wrap_nxt  = cfg_data[0];
        default: ;
      endcase
    end

    if (cmd.accept) begin
      act_nxt   = in_action;
      gfx_nxt   = mode_r;
      level_nxt = in_level;
      word_nxt  = {4'd0, pos, segs};
      grp_nxt   = 3'd0;
      cnt_nxt   = units;
      case (in_action)
        lcw_pkg::ACT_CURSOR: begin
          unit_nxt  = {1'b0, in_cursor_row};
          col_nxt   = in_cursor_col;
          cache_nxt = '0;
        end
        lcw_pkg::ACT_MARQ: begin
          pend_nxt = 1'b1;
        end
        lcw_pkg::ACT_PUT: begin
          if (mode_r && !pend_r) begin
            for (int r = 0; r < 8; r++) begin
              cache_nxt[r][col_r] = in_char_code[3'(7 - r)];
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd.step) begin
      if (cnt_r == 3'd1) begin
        cnt_nxt = units;
        grp_nxt = grp_r + 3'd1;
      end else begin
        cnt_nxt = cnt_r - 3'd1;
      end
    end

    if (cmd.finish && (act_r == lcw_pkg::ACT_PUT)) begin
      col_nxt = col_r + 3'd1;
      if (col_r == 3'd7) begin
        if (gfx_r) begin
          cache_nxt = '0;
        end
        if (unit_inc >= {1'b0, units}) begin
          unit_nxt = wrap_now ? 3'd0 : units;
          if (gfx_r) begin
            pend_nxt = 1'b0;
          end
        end else begin
          unit_nxt = unit_inc[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      count_r <= 3'd1;
      wrap_r  <= 1'b1;
      unit_r  <= 3'd0;
      col_r   <= 3'd0;
      cache_r <= '0;
      pend_r  <= 1'b0;
      act_r   <= lcw_pkg::ACT_PUT;
      gfx_r   <= 1'b0;
      grp_r   <= 3'd0;
      cnt_r   <= 3'd1;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      wrap_r  <= wrap_nxt;
      unit_r  <= unit_nxt;
      col_r   <= col_nxt;
      cache_r <= cache_nxt;
      pend_r  <= pend_nxt;
      act_r   <= act_nxt;
      gfx_r   <= gfx_nxt;
      grp_r   <= grp_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    word_r  <= word_nxt;
  end

  assign unit_match = ({1'b0, cnt_r} == unit_inc);

  always_comb begin
    if (act_r == lcw_pkg::ACT_BRIGHT) begin
      base_word = lcw_pkg::BRIGHT_WORD | {12'd0, level_r};
    end else if (gfx_r) begin
      base_word = {4'd0, {1'b0, grp_r} + 4'd1, cache_r[grp_r]};
    end else begin
      base_word = word_r;
    end
  end

  assign out_frame_word = ((act_r == lcw_pkg::ACT_BRIGHT) || unit_match) ? base_word : 16'd0;
  assign out_load_after = (cnt_r == 3'd1);
  assign out_run_last   = st.last_word;

endmodule

`default_nettype wire

@@ hw/rtl/led_chain_char_writer_unit.sv @@
`default_nettype none
// An item is taken while the unit is idle; its first word, if it has any, is shown in the
// next cycle. One word per unstalled cycle; brightness and seven-segment puts give one word
// per chained unit and graphics puts eight per unit, each followed by a closing state.
// Set cursor and start marquee keep the unit idle; a silent graphics put just closes.
// Reset is synchronous and active low; it clears the cursor, column cache and marquee flag
// and returns the registers to seven-segment mode, one unit and wrap enabled.

module led_chain_char_writer_unit #(
  parameter int MAX_UNITS = lcw_pkg::DEF_MAX_UNITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [1:0]  in_cursor_row,
  input  wire logic [2:0]  in_cursor_col,
  input  wire logic [3:0]  in_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_frame_word,
  output logic             out_load_after,
  output logic             out_run_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [2:0]  cfg_data
);

  lcw_pkg::cmd_t cmd;
  lcw_pkg::sts_t st;

  assign cfg_ready = 1'b1;

  lcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  lcw_dp #(
    .MAX_UNITS (MAX_UNITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_action      (in_action),
    .in_char_code   (in_char_code),
    .in_cursor_row  (in_cursor_row),
    .in_cursor_col  (in_cursor_col),
    .in_level       (in_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_frame_word (out_frame_word),
    .out_load_after (out_load_after),
    .out_run_last   (out_run_last)
  );

endmodule

`default_nettype wire
